@@ hw/rtl/kcd_pkg.sv @@
// package for the key click / double / long press detector: types, codes and constants
package kcd_pkg;

    localparam int KEYS        = 4;
    localparam int LEVELS_W    = 4;
    localparam int KEY_IDX_W   = 2;
    localparam int FLAG_W      = 7;
    localparam int CNT_W       = 16;
    localparam int DIV_W       = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    // flag bits
    localparam int F_HOLD   = 0;
    localparam int F_DOWN   = 1;
    localparam int F_UP     = 2;
    localparam int F_SINGLE = 3;
    localparam int F_DOUBLE = 4;
    localparam int F_LONG   = 5;
    localparam int F_REPEAT = 6;

    localparam logic [FLAG_W-1:0] HOLD_ONLY_MASK = FLAG_W'(1) << F_HOLD;

    // reset values of the setup registers
    localparam logic [DIV_W-1:0] SCAN_DIVIDER_RST     = DIV_W'(20);
    localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST = CNT_W'(1000);
    localparam logic [CNT_W-1:0] DOUBLE_GAP_TICKS_RST = CNT_W'(200);
    localparam logic [CNT_W-1:0] REPEAT_TICKS_RST     = CNT_W'(100);

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_CLEAR = 2'd2
    } command_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCAN_DIVIDER     = 2'd0,
        REG_LONG_PRESS_TICKS = 2'd1,
        REG_DOUBLE_GAP_TICKS = 2'd2,
        REG_REPEAT_TICKS     = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        PH_WAIT   = 5'b00001,
        PH_PRESS  = 5'b00010,
        PH_GAP    = 5'b00100,
        PH_SECOND = 5'b01000,
        PH_LONG   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0]           command;
        logic [LEVELS_W-1:0]  key_levels;
        logic [KEY_IDX_W-1:0] key_index;
        logic [FLAG_W-1:0]    event_mask;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [FLAG_W-1:0] key_flags;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] double_gap_ticks;
        logic [CNT_W-1:0] repeat_ticks;
    } key_cfg_t;

    typedef struct packed {
        logic              tick;
        logic              sample;
        logic              pressed;
        logic              clear;
        logic              consume;
        logic [FLAG_W-1:0] consume_mask;
    } key_ctl_t;

endpackage

@@ hw/rtl/kcd_key.sv @@
// per-key state: level, phase machine, countdown timer and event flags
module kcd_key (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  kcd_pkg::key_cfg_t             cfg,
    input  kcd_pkg::key_ctl_t             ctl,
    output logic [kcd_pkg::FLAG_W-1:0]    flags
);
    import kcd_pkg::*;

    logic              level_reg, level_next;
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cd_reg, cd_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;

    always_comb begin
        logic [CNT_W-1:0]  cd;
        logic [FLAG_W-1:0] f;
        cd         = cd_reg;
        f          = flags_reg;
        level_next = level_reg;
        phase_next = phase_reg;

        if (ctl.tick && cd_reg != '0) begin
            cd = cd_reg - CNT_W'(1);
        end

        if (ctl.sample) begin
            level_next = ctl.pressed;
            f[F_HOLD]  = ctl.pressed;
            if (ctl.pressed && !level_reg) begin
                f[F_DOWN] = 1'b1;
            end
            if (!ctl.pressed && level_reg) begin
                f[F_UP] = 1'b1;
            end
            unique case (phase_reg)
                PH_WAIT: begin
                    if (ctl.pressed) begin
                        cd         = cfg.long_press_ticks;
                        phase_next = PH_PRESS;
                    end
                end
                PH_PRESS: begin
                    if (!ctl.pressed) begin
                        cd         = cfg.double_gap_ticks;
                        phase_next = PH_GAP;
                    end else if (cd == '0) begin
                        f[F_LONG]  = 1'b1;
                        cd         = cfg.repeat_ticks;
                        phase_next = PH_LONG;
                    end
                end
                PH_GAP: begin
                    if (ctl.pressed) begin
                        f[F_DOUBLE] = 1'b1;
                        phase_next  = PH_SECOND;
                    end else if (cd == '0) begin
                        f[F_SINGLE] = 1'b1;
                        phase_next  = PH_WAIT;
                    end
                end
                PH_SECOND: begin
                    if (!ctl.pressed) begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_LONG: begin
                    if (!ctl.pressed) begin
                        phase_next = PH_WAIT;
                    end else if (cd == '0) begin
                        f[F_REPEAT] = 1'b1;
                        cd          = cfg.repeat_ticks;
                    end
                end
                default: begin
                    phase_next = PH_WAIT;
                end
            endcase
        end

        if (ctl.consume) begin
            f = f & ~ctl.consume_mask;
        end
        if (ctl.clear) begin
            f = '0;
        end

        cd_next    = cd;
        flags_next = f;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            phase_reg <= PH_WAIT;
            cd_reg    <= '0;
            flags_reg <= '0;
        end else begin
            level_reg <= level_next;
            phase_reg <= phase_next;
            cd_reg    <= cd_next;
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

@@ hw/rtl/key_click_double_long_detector.sv @@
// top level of the multi-key click, double click, long press and repeat detector
// a request waits in the request register until the result register is free or m_ready is
// high; throughput: one request per cycle unless m_ready stalls, set by the single pass
// from request register to result register; the per-key state updates in that same cycle
// reset: synchronous active-low aresetn clears all key state, the scan counter and both
// valid flags, and loads the setup registers with their default values
module key_click_double_long_detector (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  kcd_pkg::req_t                     s_req,
    output logic                              m_valid,
    input  logic                              m_ready,
    output kcd_pkg::res_t                     m_res,
    input  logic                              cfg_wr_en,
    input  logic [kcd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [kcd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import kcd_pkg::*;

    logic [DIV_W-1:0] scan_divider_reg;
    key_cfg_t         key_cfg_reg;

    req_t             req_reg;
    logic             req_valid_reg;
    res_t             res_reg, res_next;
    logic             res_valid_reg;
    logic [DIV_W-1:0] tick_count_reg, tick_count_next;

    logic             advance;
    logic             do_tick, do_sample, do_check, do_clear;
    logic             idx_valid, hit, consume;
    logic [DIV_W-1:0] tick_inc;
    logic [FLAG_W-1:0] flags_cur;
    logic [FLAG_W-1:0] flags_all [KEYS];
    key_ctl_t          key_ctl   [KEYS];

    // setup registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_divider_reg             <= SCAN_DIVIDER_RST;
            key_cfg_reg.long_press_ticks <= LONG_PRESS_TICKS_RST;
            key_cfg_reg.double_gap_ticks <= DOUBLE_GAP_TICKS_RST;
            key_cfg_reg.repeat_ticks     <= REPEAT_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SCAN_DIVIDER:     scan_divider_reg <= cfg_wdata[DIV_W-1:0];
                REG_LONG_PRESS_TICKS: key_cfg_reg.long_press_ticks <= cfg_wdata[CNT_W-1:0];
                REG_DOUBLE_GAP_TICKS: key_cfg_reg.double_gap_ticks <= cfg_wdata[CNT_W-1:0];
                REG_REPEAT_TICKS:     key_cfg_reg.repeat_ticks <= cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign advance = req_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || advance;

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

    // command decode
    always_comb begin
        do_tick  = 1'b0;
        do_check = 1'b0;
        do_clear = 1'b0;
        unique case (command_t'(req_reg.command))
            CMD_TICK:  do_tick  = advance;
            CMD_CHECK: do_check = advance;
            CMD_CLEAR: do_clear = advance;
            default: begin
            end
        endcase
    end

    // scan divider
    assign tick_inc  = tick_count_reg + DIV_W'(1);
    assign do_sample = do_tick && (tick_inc >= scan_divider_reg);

    always_comb begin
        tick_count_next = tick_count_reg;
        if (do_tick) begin
            tick_count_next = do_sample ? '0 : tick_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
        end else begin
            tick_count_reg <= tick_count_next;
        end
    end

    // flag check
    assign idx_valid = 32'(req_reg.key_index) < KEYS;
    assign flags_cur = idx_valid ? flags_all[req_reg.key_index] : '0;
    assign hit       = do_check && idx_valid && ((flags_cur & req_reg.event_mask) != '0);
    assign consume   = hit && (req_reg.event_mask != HOLD_ONLY_MASK);

    for (genvar k = 0; k < KEYS; k++) begin : g_key
        always_comb begin
            key_ctl[k].tick         = do_tick;
            key_ctl[k].sample       = do_sample;
            key_ctl[k].pressed      = (k < LEVELS_W) ? req_reg.key_levels[k % LEVELS_W] : 1'b0;
            key_ctl[k].clear        = do_clear;
            key_ctl[k].consume      = consume && (32'(req_reg.key_index) == k);
            key_ctl[k].consume_mask = req_reg.event_mask;
        end

        kcd_key u_key (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (key_cfg_reg),
            .ctl     (key_ctl[k]),
            .flags   (flags_all[k])
        );
    end

    // result register
    always_comb begin
        res_next.hit       = hit;
        res_next.key_flags = flags_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= 1'b1;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = res_valid_reg;
    assign m_res   = res_reg;

endmodule
